@@ sv/ppg_pkg.sv @@
// Package for the PPG heart rate and SpO2 tracker.
// Types, coefficients and register indexes; no dependencies.
package ppg_pkg;
  localparam int unsigned CfgIdxThreshold  = 0;
  localparam int unsigned CfgIdxRefractory = 1;
  localparam int unsigned CfgIdxContact    = 2;
  localparam int unsigned CfgIdxSpo2Min    = 3;

  localparam logic [15:0] C_HP    = 16'd2621;
  localparam logic [15:0] C_AC    = 16'd328;
  localparam logic [15:0] C_DC    = 16'd66;
  localparam logic [15:0] C_HR    = 16'd19661;
  localparam logic [15:0] C_TRACE = 16'd13107;

  typedef struct packed {
    logic [15:0] ir;
    logic [15:0] red;
    logic [15:0] prob;
  } sample_t;

  typedef struct packed {
    logic        window_ready;
    logic        beat_flag;
    logic [7:0]  heart_rate;
    logic [6:0]  oxygen_saturation;
    logic        skin_contact;
    logic [16:0] processed_trace;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEAN, ST_LEVEL, ST_BOX, ST_BEAT, ST_HRDIV, ST_HRDONE,
    ST_SPMUL, ST_SPDIV, ST_SPDONE, ST_TAIL, ST_OUT
  } state_e;

  // s + round((t - s) * c / 65536); values fit in 42 signed bits
  function automatic logic signed [41:0] blend(input logic signed [41:0] s,
                                               input logic signed [41:0] t,
                                               input logic [15:0] c);
    logic signed [59:0] p;
    p = (60'(t) - 60'(s)) * $signed({44'd0, c}) + 60'sd32768;
    return s + 42'(p >>> 16);
  endfunction
endpackage

@@ sv/ppg_heart_rate_spo2_tracker.sv @@
// Top level of the PPG heart rate and SpO2 tracker.
// Depends on ppg_pkg, ppg_front and ppg_back.
//
// One IR/red sample beat in gives one result beat out. Once the warm-up
// window fills, a sample also runs the box filter and beat logic, and it uses
// the shared one-bit-a-cycle divider for the heart rate after a beat and for
// the SpO2 ratio when the DC levels pass the SpO2 minimum. The output can
// stall the result beat; a two-beat queue decouples the input.
module ppg_heart_rate_spo2_tracker #(
  parameter int unsigned BOX_LENGTH    = 20,
  parameter int unsigned WARMUP_WINDOW = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] ir_sample_i,
  input  logic [15:0] red_sample_i,
  input  logic [15:0] beat_probability_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        window_ready_o,
  output logic        beat_flag_o,
  output logic [7:0]  heart_rate_o,
  output logic [6:0]  oxygen_saturation_o,
  output logic        skin_contact_o,
  output logic signed [16:0] processed_trace_o
);
  import ppg_pkg::*;
  logic [15:0] thr_q, contact_q, spmin_q;
  logic [7:0]  refr_q;
  sample_t s_in, q_data;
  result_t res;
  logic q_valid, q_pop;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd32768; refr_q <= 8'd20; contact_q <= 16'd2000; spmin_q <= 16'd100;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        2'(CfgIdxThreshold):  thr_q <= pwdata[15:0];
        2'(CfgIdxRefractory): refr_q <= pwdata[7:0];
        2'(CfgIdxContact):    contact_q <= pwdata[15:0];
        2'(CfgIdxSpo2Min):    spmin_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      2'(CfgIdxThreshold):  prdata = {16'd0, thr_q};
      2'(CfgIdxRefractory): prdata = {24'd0, refr_q};
      2'(CfgIdxContact):    prdata = {16'd0, contact_q};
      2'(CfgIdxSpo2Min):    prdata = {16'd0, spmin_q};
      default:              prdata = 32'd0;
    endcase
  end

  assign s_in = '{ir: ir_sample_i, red: red_sample_i, prob: beat_probability_i};
  ppg_front u_front (.clk_i, .rst_ni, .valid_i, .stall_o, .data_i(s_in),
                     .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data));
  ppg_back #(.BOX_LENGTH(BOX_LENGTH), .WARMUP_WINDOW(WARMUP_WINDOW)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .thr_i(thr_q), .refr_i(refr_q), .contact_i(contact_q), .spmin_i(spmin_q),
    .valid_o, .stall_i, .res_o(res));

  assign window_ready_o      = res.window_ready;
  assign beat_flag_o         = res.beat_flag;
  assign heart_rate_o        = res.heart_rate;
  assign oxygen_saturation_o = res.oxygen_saturation;
  assign skin_contact_o      = res.skin_contact;
  assign processed_trace_o   = res.processed_trace;
endmodule

@@ sv/ppg_front.sv @@
// Front end: two-entry queue of sample beats.
// Depends on ppg_pkg.
module ppg_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  ppg_pkg::sample_t data_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output ppg_pkg::sample_t q_data_o
);
  import ppg_pkg::*;
  sample_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push;
  assign stall_o   = cnt_q == 2'd2;
  assign push      = valid_i && !stall_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_data_o  = mem_q[rd_q];
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (q_pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

@@ sv/ppg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module ppg_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [63:0]  quo_o
);
  logic [63:0] rem_q, quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [64:0] sh;
  assign sh     = {rem_q, quo_q[63]};
  assign quo_o  = quo_q;
  assign done_o = busy_q && cnt_q == 7'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 7'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 64'd0; quo_q <= num_i; den_q <= den_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      if (sh >= {1'b0, den_q}) begin
        rem_q <= 64'(sh - {1'b0, den_q});
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= sh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end
endmodule

@@ sv/ppg_back.sv @@
// Back end: filter state, box filter, beat logic, rate and SpO2 sequencer.
// Depends on ppg_pkg and ppg_div.
module ppg_back #(
  parameter int unsigned BOX_LENGTH    = 20,
  parameter int unsigned WARMUP_WINDOW = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  ppg_pkg::sample_t q_data_i,
  input  logic [15:0]      thr_i,
  input  logic [7:0]       refr_i,
  input  logic [15:0]      contact_i,
  input  logic [15:0]      spmin_i,
  output logic             valid_o,
  input  logic             stall_i,
  output ppg_pkg::result_t res_o
);
  import ppg_pkg::*;
  localparam int PW = BOX_LENGTH > 1 ? $clog2(BOX_LENGTH) : 1;
  localparam int TW = 16 + $clog2(BOX_LENGTH + 1);

  state_e st_q, st_d;
  sample_t in_q;
  logic signed [41:0] ir_mean_q, red_mean_q, ir_ac_q, red_ac_q, ir_dc_q, red_dc_q;
  logic signed [41:0] slow_q, trace_q, iavg_q, ir_hp_q, red_hp_q;
  logic [31:0] seen_q, last_q, gap_q;
  logic [15:0] box_mem [BOX_LENGTH];
  logic [15:0] box_rd_q;
  logic [PW-1:0] pos_q;
  logic [TW-1:0] total_q, total_n;
  logic [7:0] rate_q;
  logic [6:0] sat_q;
  logic ready_q, beat_q, box_full_q;
  logic [16:0] trace_out_q;
  logic [63:0] num_q, den_q;
  logic div_start;
  logic [63:0] div_num, div_den, quo;
  logic div_done;
  logic signed [41:0] x, r, ivq, iavg_new;
  logic [31:0] seen_n;
  logic [23:0] iv;
  logic [20:0] sp25;

  assign x = 42'(signed'({1'b0, in_q.ir, 16'd0}));
  assign r = 42'(signed'({1'b0, in_q.red, 16'd0}));
  assign seen_n = seen_q + 32'd1;
  assign iv = gap_q > 32'hFFFFFF ? 24'hFFFFFF : gap_q[23:0];
  assign ivq = 42'(signed'({1'b0, iv, 16'd0}));
  assign iavg_new = iavg_q == 42'sd0 ? ivq : blend(iavg_q, ivq, C_HR);
  assign total_n = TW'(total_q - TW'(box_rd_q) + TW'(in_q.prob));
  assign sp25 = 21'(quo[15:0]) * 21'd25;

  ppg_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                 .den_i(div_den), .done_o(div_done), .quo_o(quo));

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (q_valid_i) st_d = ST_MEAN;
      ST_MEAN:   st_d = ST_LEVEL;
      ST_LEVEL:  st_d = ready_q ? ST_BOX : ST_TAIL;
      ST_BOX:    st_d = ST_BEAT;
      ST_BEAT: begin
        if (beat_q && last_q != 32'd0 && iavg_new > 42'sd0) st_d = ST_HRDIV;
        else st_d = ST_SPMUL;
      end
      ST_HRDIV:  st_d = ST_HRDONE;
      ST_HRDONE: if (div_done) st_d = ST_SPMUL;
      ST_SPMUL: begin
        if (ir_dc_q > 42'(signed'({1'b0, spmin_i, 16'd0})) &&
            red_dc_q > 42'(signed'({1'b0, spmin_i, 16'd0}))) st_d = ST_SPDIV;
        else st_d = ST_TAIL;
      end
      ST_SPDIV: begin
        if (den_q == 64'd0 || num_q >= {den_q[62:0], 1'b0}) st_d = ST_TAIL;
        else st_d = ST_SPDONE;
      end
      ST_SPDONE: if (div_done) st_d = ST_TAIL;
      ST_TAIL:   st_d = ST_OUT;
      ST_OUT:    if (!stall_i) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = st_q == ST_IDLE && q_valid_i;
    valid_o   = st_q == ST_OUT;
    div_start = 1'b0;
    div_num   = 64'd0;
    div_den   = 64'd1;
    if (st_q == ST_HRDIV) begin
      div_start = 1'b1;
      div_num   = 64'd6000 << 32;
      div_den   = 64'(unsigned'(iavg_q));
    end else if (st_q == ST_SPDIV && st_d == ST_SPDONE) begin
      div_start = 1'b1;
      div_num   = num_q << 14;
      div_den   = den_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ir_mean_q <= '0; red_mean_q <= '0; ir_ac_q <= '0; red_ac_q <= '0;
      ir_dc_q <= '0; red_dc_q <= '0; slow_q <= '0; trace_q <= '0; iavg_q <= '0;
      seen_q <= '0; last_q <= '0; pos_q <= '0; total_q <= '0;
      rate_q <= '0; sat_q <= '0; box_full_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_MEAN: begin
          ir_mean_q  <= blend(ir_mean_q, x, C_HP);
          red_mean_q <= blend(red_mean_q, r, C_HP);
          seen_q     <= seen_n;
        end
        ST_LEVEL: begin
          ir_ac_q  <= blend(ir_ac_q, ir_hp_q < 0 ? -ir_hp_q : ir_hp_q, C_AC);
          red_ac_q <= blend(red_ac_q, red_hp_q < 0 ? -red_hp_q : red_hp_q, C_AC);
          ir_dc_q  <= blend(ir_dc_q, x, C_DC);
          red_dc_q <= blend(red_dc_q, r, C_DC);
        end
        ST_BOX: begin
          total_q <= total_n;
          pos_q   <= pos_q == PW'(BOX_LENGTH - 1) ? '0 : pos_q + PW'(1);
          if (pos_q == PW'(BOX_LENGTH - 1)) box_full_q <= 1'b1;
        end
        ST_BEAT: if (beat_q) begin
          if (last_q != 32'd0) iavg_q <= iavg_new;
          last_q <= seen_q;
        end
        ST_HRDONE: if (div_done) begin
          if (quo[63:16] + 48'(quo[15]) < 48'd30) rate_q <= 8'd30;
          else if (quo[63:16] + 48'(quo[15]) > 48'd240) rate_q <= 8'd240;
          else rate_q <= 8'(quo[23:16] + 8'(quo[15]));
        end
        ST_SPDIV: if (den_q != 64'd0 && num_q >= {den_q[62:0], 1'b0}) sat_q <= 7'd70;
        ST_SPDONE: if (div_done) begin
          if (sp25 > 21'(40 * 16384 + 8192)) sat_q <= 7'd70;
          else if (sp25 <= 21'(10 * 16384 + 8192)) sat_q <= 7'd100;
          else sat_q <= 7'((21'(110 * 16384 + 8192) - sp25) >> 14);
        end
        ST_TAIL: begin
          slow_q  <= blend(slow_q, x, C_DC);
          trace_q <= blend(trace_q, ir_hp_q, C_TRACE);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        in_q <= q_data_i;
        trace_out_q <= trace_q[32:16];
        beat_q <= 1'b0;
      end
      ST_MEAN: begin
        ir_hp_q  <= x - blend(ir_mean_q, x, C_HP);
        red_hp_q <= r - blend(red_mean_q, r, C_HP);
        ready_q  <= seen_n >= 32'(WARMUP_WINDOW);
        gap_q    <= seen_n - last_q;
      end
      ST_LEVEL: box_rd_q <= box_full_q ? box_mem[pos_q] : 16'd0;
      ST_BOX: begin
        box_mem[pos_q] <= in_q.prob;
        beat_q <= (TW+16)'(total_n) >= (TW+16)'(thr_i) * (TW+16)'(BOX_LENGTH)
                  && gap_q >= 32'(refr_i);
      end
      ST_SPMUL: begin
        num_q <= 64'(red_ac_q[39:8]) * 64'(ir_dc_q[39:8]);
        den_q <= 64'(ir_ac_q[39:8]) * 64'(red_dc_q[39:8]);
      end
      default: ;
    endcase
  end

  assign res_o.window_ready      = ready_q;
  assign res_o.beat_flag         = beat_q;
  assign res_o.heart_rate        = rate_q;
  assign res_o.oxygen_saturation = sat_q;
  assign res_o.skin_contact      = slow_q > 42'(signed'({1'b0, contact_i, 16'd0}));
  assign res_o.processed_trace   = trace_out_q;
endmodule

@@ sv/ppg_checker.sv @@
// Port-level checks for the tracker, bound to the top level.
// Depends on ppg_heart_rate_spo2_tracker.
module ppg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       stall_i,
  input logic       beat_flag_o,
  input logic       window_ready_o,
  input logic [7:0] heart_rate_o,
  input logic [6:0] oxygen_saturation_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(heart_rate_o)) else $error("hold");
  a_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && beat_flag_o |-> window_ready_o) else $error("beat early");
  a_hr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> heart_rate_o == 8'd0 || (heart_rate_o >= 8'd30 && heart_rate_o <= 8'd240))
    else $error("rate");
  a_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> oxygen_saturation_o == 7'd0 ||
    (oxygen_saturation_o >= 7'd70 && oxygen_saturation_o <= 7'd100)) else $error("spo2");
endmodule

bind ppg_heart_rate_spo2_tracker ppg_checker u_chk (.*);

@@ bench/ppg_tracker_checker.sv @@
// Checker for the PPG heart rate and SpO2 tracker: tracks config writes,
// predicts each result beat from accepted sample beats and compares them.
// Depends on ppg_pkg.
`timescale 1ns / 100ps
module ppg_tracker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [15:0] ir_sample_i,
  input  logic [15:0] red_sample_i,
  input  logic [15:0] beat_probability_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic        window_ready_o,
  input  logic        beat_flag_o,
  input  logic [7:0]  heart_rate_o,
  input  logic [6:0]  oxygen_saturation_o,
  input  logic        skin_contact_o,
  input  logic signed [16:0] processed_trace_o,
  output int          errors,
  output int          pending
);
  import ppg_pkg::*;

  localparam int BoxLen = 20;
  localparam int Warmup = 256;

  logic [15:0] thr_q;
  logic [7:0]  refr_q;
  logic [15:0] contact_q, dcmin_q;
  longint ir_m, red_m, ir_ac, red_ac, ir_dc, red_dc, ir_slow, trace_s, iv_avg;
  logic [31:0] seen, last_beat;
  logic [15:0] box [BoxLen];
  int unsigned box_pos, box_sum;
  logic [7:0]  rate_q;
  logic [6:0]  sat_q;
  result_t     expected_results[$];

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint mix(longint s, longint t, longint c);
    return s + fl16((t - s) * c + 32768);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic spo2_update();
    logic [63:0] a, b, c, d, num, den, q;
    longint v;
    a = 64'(red_ac) >> 8;
    b = 64'(ir_dc) >> 8;
    c = 64'(ir_ac) >> 8;
    d = 64'(red_dc) >> 8;
    num = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    den = {32'd0, c[31:0]} * {32'd0, d[31:0]};
    if (den == 0) return;
    if (num >= 2 * den) begin
      sat_q = 70;
      return;
    end
    q = (num << 14) / den;
    v = 110 * 16384 + 8192 - 25 * longint'(q);
    if (v < 70 * 16384) sat_q = 70;
    else if (v >= 100 * 16384) sat_q = 100;
    else sat_q = 7'(v >>> 14);
  endtask

  task automatic predict_sample(logic [15:0] ir, logic [15:0] rd, logic [15:0] pb);
    longint x, r, trace_out, ir_hp, red_hp, ivq;
    logic [31:0] gap, iv;
    logic [63:0] hr;
    logic rdy, beat;
    int unsigned pos;
    result_t e;
    x = longint'(ir) * 65536;
    r = longint'(rd) * 65536;
    trace_out = fl16(trace_s);
    beat = 0;
    ir_m = mix(ir_m, x, C_HP);
    ir_hp = x - ir_m;
    red_m = mix(red_m, r, C_HP);
    red_hp = r - red_m;
    ir_ac = mix(ir_ac, absl(ir_hp), C_AC);
    red_ac = mix(red_ac, absl(red_hp), C_AC);
    ir_dc = mix(ir_dc, x, C_DC);
    red_dc = mix(red_dc, r, C_DC);
    seen = seen + 1;
    rdy = seen >= Warmup;
    if (rdy) begin
      pos = box_pos % BoxLen;
      gap = seen - last_beat;
      box_sum = box_sum - box[pos] + pb;
      box[pos] = pb;
      box_pos = (pos + 1) % BoxLen;
      if (longint'(box_sum) >= longint'(thr_q) * BoxLen && gap >= refr_q) begin
        beat = 1;
        if (last_beat != 0) begin
          iv = gap > 32'hFFFFFF ? 32'hFFFFFF : gap;
          ivq = longint'(iv) * 65536;
          if (iv_avg == 0) iv_avg = ivq;
          else iv_avg = mix(iv_avg, ivq, C_HR);
          if (iv_avg > 0) begin
            hr = ((64'd6000 << 32) / 64'(iv_avg) + 32768) >> 16;
            if (hr < 30) hr = 30;
            if (hr > 240) hr = 240;
            rate_q = 8'(hr);
          end
        end
        last_beat = seen;
      end
      if (ir_dc > longint'(dcmin_q) * 65536 && red_dc > longint'(dcmin_q) * 65536)
        spo2_update();
    end
    ir_slow = mix(ir_slow, x, C_DC);
    trace_s = mix(trace_s, ir_hp, C_TRACE);
    e.window_ready = rdy;
    e.beat_flag = beat;
    e.heart_rate = rate_q;
    e.oxygen_saturation = sat_q;
    e.skin_contact = ir_slow > longint'(contact_q) * 65536;
    e.processed_trace = 17'(trace_out);
    expected_results.push_back(e);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q = 32768; refr_q = 20; contact_q = 2000; dcmin_q = 100;
      ir_m = 0; red_m = 0; ir_ac = 0; red_ac = 0; ir_dc = 0; red_dc = 0;
      ir_slow = 0; trace_s = 0; iv_avg = 0;
      seen = 0; last_beat = 0; box_pos = 0; box_sum = 0; rate_q = 0; sat_q = 0;
      for (int i = 0; i < BoxLen; i++) box[i] = 0;
      expected_results.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr[3:2]))
          CfgIdxThreshold:  thr_q = pwdata[15:0];
          CfgIdxRefractory: refr_q = pwdata[7:0];
          CfgIdxContact:    contact_q = pwdata[15:0];
          CfgIdxSpo2Min:    dcmin_q = pwdata[15:0];
          default: ;
        endcase
      end
      if (valid_o && !stall_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected result beat", 0, 0);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (window_ready_o !== e.window_ready)
            report("window_ready", window_ready_o, e.window_ready);
          if (beat_flag_o !== e.beat_flag) report("beat_flag", beat_flag_o, e.beat_flag);
          if (heart_rate_o !== e.heart_rate) report("heart_rate", heart_rate_o, e.heart_rate);
          if (oxygen_saturation_o !== e.oxygen_saturation)
            report("oxygen_saturation", oxygen_saturation_o, e.oxygen_saturation);
          if (skin_contact_o !== e.skin_contact)
            report("skin_contact", skin_contact_o, e.skin_contact);
          if (processed_trace_o !== e.processed_trace)
            report("processed_trace", processed_trace_o, $signed(e.processed_trace));
        end
      end
      if (valid_i && !stall_o) predict_sample(ir_sample_i, red_sample_i, beat_probability_i);
      pending = expected_results.size();
    end
  end
endmodule

@@ bench/ppg_heart_rate_spo2_tracker_test.sv @@
// Testbench top for the PPG heart rate and SpO2 tracker: drives config and
// sample beats under varying idle/stall patterns; checking is in
// ppg_tracker_checker. Depends on ppg_pkg and the tracker RTL.
`timescale 1ns / 100ps
module ppg_heart_rate_spo2_tracker_test;
  import ppg_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic valid_i = 0, stall_o, valid_o, stall_i = 0;
  logic [15:0] ir_sample_i = 0, red_sample_i = 0, beat_probability_i = 0;
  logic window_ready_o, beat_flag_o, skin_contact_o;
  logic [7:0] heart_rate_o;
  logic [6:0] oxygen_saturation_o;
  logic signed [16:0] processed_trace_o;
  int errors, pending;
  int send_idle = 0, recv_stall = 0, hold_cycles = 0;
  longint cycles = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  ppg_heart_rate_spo2_tracker dut (.*);

  ppg_tracker_checker chk (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("ppg_heart_rate_spo2_tracker: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      stall_i <= 1;
    end else begin
      stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic cfg_write(int idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 4'(idx * 4); pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_sample(logic [15:0] ir, logic [15:0] rd, logic [15:0] pb);
    while ($urandom_range(99) < send_idle) begin
      @(posedge clk_i);
      valid_i <= 0;
    end
    @(posedge clk_i);
    valid_i <= 1; ir_sample_i <= ir; red_sample_i <= rd; beat_probability_i <= pb;
    do @(posedge clk_i); while (stall_o);
    valid_i <= 0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic run_pulses(int n, int period, logic [15:0] base, logic [15:0] amp);
    int ph;
    logic [15:0] ir, rd, pb;
    for (int i = 0; i < n; i++) begin
      ph = i % period;
      ir = 16'(base + (ph < period / 4 ? amp : 16'd0) + 16'($urandom_range(31)));
      rd = 16'(base - 16'(base / 8) + (ph < period / 4 ? amp / 2 : 16'd0)
               + 16'($urandom_range(31)));
      pb = (ph < 3) ? 16'($urandom_range(65535, 50000)) : 16'($urandom_range(8000));
      if ($urandom_range(19) == 0) begin
        ir = 16'($urandom); rd = 16'($urandom); pb = 16'($urandom);
      end
      send_sample(ir, rd, pb);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    cfg_write(0, 32768);
    // directed extremes
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'hFFFF, 16'd0, 16'h8000);
    send_sample(16'd0, 16'hFFFF, 16'h7FFF);
    for (int i = 0; i < 16; i++) send_sample(16'h5555 << (i % 2), 16'hAAAA >> (i % 2), 16'h5555);
    drain();
    cfg_write(1, 0); cfg_write(2, 0); cfg_write(3, 0);
    // warm-up to the window with steady signal
    for (int i = 0; i < 240; i++) send_sample(16'd30000, 16'd20000, 16'd0);
    drain();
    // zero threshold and refractory: beats every sample
    cfg_write(0, 0);
    for (int i = 0; i < 10; i++) send_sample(16'(30000 + i * 500), 16'd20000, 16'hFFFF);
    drain();
    cfg_write(0, 32'hFFFF); cfg_write(1, 255); cfg_write(2, 32'hFFFF); cfg_write(3, 32'hFFFF);
    send_idle = 0; recv_stall = 0;
    run_pulses(60, 40, 20000, 8000);
    drain();
    cfg_write(0, 30000); cfg_write(1, 20); cfg_write(2, 2000); cfg_write(3, 100);
    send_idle = 64; recv_stall = 0;
    run_pulses(300, 60, 25000, 6000);
    hold_cycles = 2000;
    send_idle = 0;
    run_pulses(200, 50, 40000, 10000);
    drain();
    cfg_write(1, 8); cfg_write(3, 1000);
    send_idle = 0; recv_stall = 64;
    run_pulses(300, 25, 10000, 3000);
    drain();
    cfg_write(0, 20000); cfg_write(1, 35); cfg_write(2, 50000);
    send_idle = 31; recv_stall = 31;
    run_pulses(300, 80, 50000, 12000);
    drain();
    cfg_write(0, $urandom_range(65535)); cfg_write(3, 0);
    send_idle = 0; recv_stall = 0;
    for (int i = 0; i < 80; i++) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
    if (errors == 0) begin
      $display("ppg_heart_rate_spo2_tracker: match");
    end else begin
      $display("ppg_heart_rate_spo2_tracker: mismatch");
    end
    $finish;
  end
endmodule

@@ ppg_heart_rate_spo2_tracker.f @@
sv/ppg_pkg.sv
sv/ppg_front.sv
sv/ppg_div.sv
sv/ppg_back.sv
sv/ppg_heart_rate_spo2_tracker.sv
sv/ppg_checker.sv
bench/ppg_tracker_checker.sv
bench/ppg_heart_rate_spo2_tracker_test.sv
